// ===== rtl/cbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and codes of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int PA_W       = 23;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_TYPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT    = 2'd3;

    // mapper kinds
    localparam logic [2:0] MAP_NONE = 3'd0;
    localparam logic [2:0] MAP_MBC1 = 3'd1;
    localparam logic [2:0] MAP_MBC2 = 3'd2;
    localparam logic [2:0] MAP_MBC3 = 3'd3;
    localparam logic [2:0] MAP_MBC5 = 3'd4;

    // result targets
    localparam logic [2:0] TGT_ROM     = 3'd0;
    localparam logic [2:0] TGT_RAM     = 3'd1;
    localparam logic [2:0] TGT_CLOCK   = 3'd2;
    localparam logic [2:0] TGT_OPEN    = 3'd3;
    localparam logic [2:0] TGT_NONCART = 3'd4;

    // clock register selects
    localparam logic [7:0] SEL_SEC   = 8'd8;
    localparam logic [7:0] SEL_MIN   = 8'd9;
    localparam logic [7:0] SEL_HOUR  = 8'd10;
    localparam logic [7:0] SEL_DAYLO = 8'd11;
    localparam logic [7:0] SEL_FLAGS = 8'd12;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    typedef struct packed {
        logic [2:0] mapper_type;
        logic [9:0] rom_bank_count;
        logic [4:0] ram_bank_count;
        logic       ram_present;
    } t_cfg;

    typedef struct packed {
        logic [8:0] rom_sel;
        logic [7:0] ram_sel;
        logic       ram_en;
        logic       mode;
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hour;
        logic [8:0] days;
        logic [7:0] flags;
        logic       dirty;
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } t_req;

    typedef struct packed {
        logic [2:0]      target;
        logic [PA_W-1:0] physical_address;
        logic [7:0]      read_byte;
        logic            ram_write_strobe;
        logic            nibble_only;
        logic            save_dirty;
    } t_rsp;

    localparam t_cfg CFG_RESET = '{
        mapper_type: MAP_NONE, rom_bank_count: 10'd2,
        ram_bank_count: 5'd0, ram_present: 1'b0
    };

    localparam t_state STATE_RESET = '{
        rom_sel: 9'd1, ram_sel: 8'd0, ram_en: 1'b0, mode: 1'b0,
        sec: 8'd0, min: 8'd0, hour: 8'd0, days: 9'd0, flags: 8'd0,
        dirty: 1'b0
    };

endpackage
`default_nettype wire

// ===== rtl/cbm_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_in_if
// Bus access channel: one CPU access per word.
// ----------------------------------------------------------------------------
interface cbm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;

    modport source (output valid, kind, bus_address, write_byte, input ready);
    modport sink   (input valid, kind, bus_address, write_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/cbm_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_out_if
// Decode result channel: one result per word.
// ----------------------------------------------------------------------------
interface cbm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [22:0] physical_address;
    logic [7:0]  read_byte;
    logic        ram_write_strobe;
    logic        nibble_only;
    logic        save_dirty;

    modport source (output valid, target, physical_address, read_byte,
                    ram_write_strobe, nibble_only, save_dirty, input ready);
    modport sink   (input valid, target, physical_address, read_byte,
                    ram_write_strobe, nibble_only, save_dirty, output ready);
endinterface
`default_nettype wire

// ===== rtl/cbm_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module cbm_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_we,
    input  wire logic [cbm_pkg::CFG_IDX_W-1:0]   i_idx,
    input  wire logic [cbm_pkg::CFG_DATA_W-1:0]  i_data,
    output cbm_pkg::t_cfg                        o_cfg
);
    import cbm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                CFG_MAPPER_TYPE:    n_cfg.mapper_type    = i_data[2:0];
                CFG_ROM_BANK_COUNT: n_cfg.rom_bank_count = i_data[9:0];
                CFG_RAM_BANK_COUNT: n_cfg.ram_bank_count = i_data[4:0];
                CFG_RAM_PRESENT:    n_cfg.ram_present    = i_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/cbm_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_core
// Access decode and bank register update for one bus word.
// ----------------------------------------------------------------------------
module cbm_core #(
    parameter int ROM_ADDR_BITS = 23,
    parameter int RAM_ADDR_BITS = 17
) (
    input  wire cbm_pkg::t_cfg   i_cfg,
    input  wire cbm_pkg::t_state i_state,
    input  wire cbm_pkg::t_req   i_req,
    output cbm_pkg::t_rsp        o_rsp,
    output cbm_pkg::t_state      o_state
);
    import cbm_pkg::*;

    localparam logic [PA_W-1:0] ROM_MASK = PA_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);
    localparam logic [PA_W-1:0] RAM_MASK = PA_W'((64'd1 << RAM_ADDR_BITS) - 64'd1);

    function automatic logic [PA_W-1:0] rom_at(input logic [8:0] bank,
                                               input logic [15:0] a);
        return {bank, a[13:0]} & ROM_MASK;
    endfunction

    function automatic logic [PA_W-1:0] ram_at(input logic [7:0] bank,
                                               input logic [15:0] a);
        return PA_W'({bank, a[12:0]}) & RAM_MASK;
    endfunction

    function automatic logic is_clk_sel(input logic [7:0] b);
        return (b >= SEL_SEC) && (b <= SEL_FLAGS);
    endfunction

    logic [2:0]  mt;
    logic [15:0] a;
    logic [7:0]  v;
    logic        in_rom;
    logic        in_ram;
    logic        en;
    logic        ram_ok;
    logic [4:0]  b5;
    logic [6:0]  b7;
    logic [3:0]  b4;
    t_state      s;
    t_rsp        rsp;

    always_comb begin
        mt     = (i_cfg.mapper_type > MAP_MBC5) ? MAP_NONE : i_cfg.mapper_type;
        a      = i_req.bus_address;
        v      = i_req.write_byte;
        in_rom = !a[15];
        in_ram = (a[15:13] == 3'b101);
        en     = i_state.ram_en;
        ram_ok = en && i_cfg.ram_present;
        b5     = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
        b7     = (v[6:0] == 7'd0) ? 7'd1 : v[6:0];
        b4     = (v[3:0] == 4'd0) ? 4'd1 : v[3:0];
        s      = i_state;
        rsp    = '0;
        rsp.target = TGT_NONCART;

        if (!in_rom && !in_ram) begin
            rsp.target = TGT_NONCART;
        end else if (!i_req.kind) begin
            if (in_rom) begin
                rsp.target = TGT_ROM;
                if (!a[14] || mt == MAP_NONE) begin
                    rsp.physical_address = PA_W'(a) & ROM_MASK;
                end else if (mt == MAP_MBC1 && i_state.mode) begin
                    rsp.physical_address = rom_at({4'd0, i_state.rom_sel[4:0]}, a);
                end else begin
                    rsp.physical_address = rom_at(i_state.rom_sel, a);
                end
            end else begin
                rsp.target    = TGT_OPEN;
                rsp.read_byte = 8'hFF;
                unique case (mt)
                    MAP_MBC1: begin
                        if (ram_ok) begin
                            rsp.target    = TGT_RAM;
                            rsp.read_byte = 8'd0;
                            rsp.physical_address = ram_at(
                                i_state.mode ? i_state.ram_sel : 8'd0, a);
                        end
                    end
                    MAP_MBC2: begin
                        if (a[12:9] != 4'd0) begin
                            rsp.read_byte = 8'd0;
                        end else if (en) begin
                            rsp.target           = TGT_RAM;
                            rsp.read_byte        = 8'd0;
                            rsp.nibble_only      = 1'b1;
                            rsp.physical_address = PA_W'(a[12:0]) & RAM_MASK;
                        end
                    end
                    MAP_MBC3: begin
                        if (en && is_clk_sel(i_state.ram_sel)) begin
                            rsp.target = TGT_CLOCK;
                            unique case (i_state.ram_sel)
                                SEL_SEC:   rsp.read_byte = i_state.sec;
                                SEL_MIN:   rsp.read_byte = i_state.min;
                                SEL_HOUR:  rsp.read_byte = i_state.hour;
                                SEL_DAYLO: rsp.read_byte = i_state.days[7:0];
                                default:   rsp.read_byte =
                                    i_state.flags | {7'd0, i_state.days[8]};
                            endcase
                        end else if (ram_ok && i_state.ram_sel <= 8'd3) begin
                            rsp.target    = TGT_RAM;
                            rsp.read_byte = 8'd0;
                            rsp.physical_address = ram_at(i_state.ram_sel, a);
                        end
                    end
                    MAP_MBC5: begin
                        if (ram_ok) begin
                            rsp.target    = TGT_RAM;
                            rsp.read_byte = 8'd0;
                            rsp.physical_address = ram_at(i_state.ram_sel, a);
                        end
                    end
                    default: rsp.read_byte = 8'd0;
                endcase
            end
        end else begin
            rsp.target = TGT_OPEN;
            if (in_rom) begin
                // control writes, a[14:13] picks the register window
                unique case (mt)
                    MAP_MBC1: begin
                        unique case (a[14:13])
                            2'd0: s.ram_en = (v[3:0] == RAM_EN_KEY);
                            2'd1: s.rom_sel = {i_state.rom_sel[8:5], b5};
                            2'd2: begin
                                if (i_state.mode) begin
                                    s.ram_sel = {6'd0, v[1:0]};
                                end else begin
                                    s.rom_sel = {i_state.rom_sel[8:7], v[1:0],
                                                 i_state.rom_sel[4:0]};
                                end
                            end
                            default: s.mode = v[0];
                        endcase
                    end
                    MAP_MBC2: begin
                        if (a[14:13] == 2'd0 && !a[8]) begin
                            s.ram_en = (v[3:0] == RAM_EN_KEY);
                        end else if (a[14:13] == 2'd1 && a[8]) begin
                            s.rom_sel = {5'd0, b4};
                        end
                    end
                    MAP_MBC3: begin
                        unique case (a[14:13])
                            2'd0:    s.ram_en = (v[3:0] == RAM_EN_KEY);
                            2'd1:    s.rom_sel = {2'd0, b7};
                            2'd2:    s.ram_sel = v;
                            default: s.ram_en = i_state.ram_en; // latch not modeled
                        endcase
                    end
                    MAP_MBC5: begin
                        unique case (a[14:13])
                            2'd0: s.ram_en = (v[3:0] == RAM_EN_KEY);
                            2'd1: begin
                                if (!a[12]) begin
                                    s.rom_sel = {i_state.rom_sel[8], v};
                                end else begin
                                    s.rom_sel = {v[0], i_state.rom_sel[7:0]};
                                end
                            end
                            2'd2:    s.ram_sel = {4'd0, v[3:0]};
                            default: s.ram_en = i_state.ram_en;
                        endcase
                    end
                    default: s = i_state;
                endcase
            end else if (en) begin
                unique case (mt)
                    MAP_MBC1: begin
                        if (i_cfg.ram_present) begin
                            rsp.target           = TGT_RAM;
                            rsp.ram_write_strobe = 1'b1;
                            rsp.physical_address = ram_at(
                                i_state.mode ? i_state.ram_sel : 8'd0, a);
                        end
                    end
                    MAP_MBC2: begin
                        if (a[12:9] == 4'd0) begin
                            rsp.target           = TGT_RAM;
                            rsp.ram_write_strobe = 1'b1;
                            rsp.nibble_only      = 1'b1;
                            rsp.physical_address = PA_W'(a[12:0]) & RAM_MASK;
                        end
                    end
                    MAP_MBC3: begin
                        if (is_clk_sel(i_state.ram_sel)) begin
                            rsp.target = TGT_CLOCK;
                            unique case (i_state.ram_sel)
                                SEL_SEC:   s.sec  = v;
                                SEL_MIN:   s.min  = v;
                                SEL_HOUR:  s.hour = v;
                                SEL_DAYLO: s.days = {i_state.days[8], v};
                                default: begin
                                    s.flags = v;
                                    s.days  = {v[0], i_state.days[7:0]};
                                end
                            endcase
                        end else if (i_cfg.ram_present && i_state.ram_sel <= 8'd3) begin
                            rsp.target           = TGT_RAM;
                            rsp.ram_write_strobe = 1'b1;
                            rsp.physical_address = ram_at(i_state.ram_sel, a);
                        end
                    end
                    MAP_MBC5: begin
                        if (i_cfg.ram_present) begin
                            rsp.target           = TGT_RAM;
                            rsp.ram_write_strobe = 1'b1;
                            rsp.physical_address = ram_at(i_state.ram_sel, a);
                        end
                    end
                    default: rsp.target = TGT_OPEN;
                endcase
            end

            if (rsp.ram_write_strobe) begin
                s.dirty = 1'b1;
            end
            // bank numbers past the fitted banks fall back to the old value
            if ({1'b0, s.rom_sel} >= i_cfg.rom_bank_count) begin
                s.rom_sel = i_state.rom_sel;
            end
            if (s.ram_sel >= {3'd0, i_cfg.ram_bank_count} &&
                !(mt == MAP_MBC3 && is_clk_sel(s.ram_sel))) begin
                s.ram_sel = i_state.ram_sel;
            end
        end

        rsp.save_dirty = s.dirty;
        o_rsp   = rsp;
        o_state = s;
    end

endmodule
`default_nettype wire

// ===== rtl/cartridge_bank_mapper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Cartridge memory bank controller: decodes CPU bus words to ROM, RAM,
// clock, open bus or non-cartridge space and keeps the bank registers.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word passes the input register, then the result
//   register, with one decode pass between the two registers.
// Throughput: 1 word per cycle while the result stage is not stalled.
// Reset: synchronous, active low; clears both pipeline stages, the bank and
//   clock registers and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper #(
    parameter int ROM_ADDR_BITS = 23,   // 15..23
    parameter int RAM_ADDR_BITS = 17    // 9..17
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [cbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cbm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // bus access words in, decode results out
    cbm_in_if.sink                              i_req,
    cbm_out_if.source                           o_rsp
);
    import cbm_pkg::*;

    // input stage
    logic   r_in_vld;
    t_req   r_in;
    // result stage
    logic   r_out_vld;
    t_rsp   r_out;
    // mapper state, updated when a word leaves the input stage
    t_state r_state;

    t_cfg   cfg;
    t_rsp   core_rsp;
    t_state n_state;
    logic   advance;
    logic   in_take;

    cbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    cbm_core #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS),
        .RAM_ADDR_BITS (RAM_ADDR_BITS)
    ) u_core (
        .i_cfg   (cfg),
        .i_state (r_state),
        .i_req   (r_in),
        .o_rsp   (core_rsp),
        .o_state (n_state)
    );

    // A word moves to the result stage when that stage is empty or drains
    // this cycle; the input stage refills in the same cycle.
    assign advance     = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || advance;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= STATE_RESET;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end

            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.kind        <= i_req.kind;
            r_in.bus_address <= i_req.bus_address;
            r_in.write_byte  <= i_req.write_byte;
        end
        if (advance) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.target           = r_out.target;
    assign o_rsp.physical_address = r_out.physical_address;
    assign o_rsp.read_byte        = r_out.read_byte;
    assign o_rsp.ram_write_strobe = r_out.ram_write_strobe;
    assign o_rsp.nibble_only      = r_out.nibble_only;
    assign o_rsp.save_dirty       = r_out.save_dirty;

endmodule
`default_nettype wire
